// File: hw/rtl/bft_pkg.sv
package bft_pkg;

	localparam int unsigned TABLE_WORDS_DEF = 1048576;
	localparam int unsigned NUM_HASH = 8;
	localparam int unsigned HASH_W = 32;
	// The word index is formed in steps for the reciprocal product, the
	// back-multiplication by the word count and the final correction.
	localparam int unsigned DIV_STEPS = 3;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] MYSQL_ADDEND_INIT = 32'd4;
	localparam logic [31:0] MYSQL_ADDEND_INC = 32'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} bft_state_t;

	typedef struct packed {
		logic clr_we;
		logic absorb;
		logic seen_init;
		logic div_load;
		logic div_step;
		logic mem_read;
		logic check;
		logic next_probe;
		logic out_load;
		logic restart;
	} bft_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_last;
		logic last_probe;
		logic out_busy;
	} bft_sts_t;

	function automatic logic [31:0] hash_init(input logic [2:0] k);
		logic [31:0] v;
		unique case (k)
			3'd4: v = 32'd1;
			3'd5: v = 32'hFFFFFFFF;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] hash_final(input logic [2:0] k, input logic [31:0] h);
		logic [31:0] v;
		unique case (k)
			3'd2: v = h & 32'h7FFFFFFF;
			3'd5: v = ~h;
			default: v = h;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/bloom_filter_test_and_set.sv
// Sequence: a key byte not marked last is absorbed; a last byte is absorbed and then followed by
// eight probes (load, 3 remainder steps, read, check) and the posting of the result.
// Throughput: one byte per cycle inside a key; after a key end no byte is taken until the
// probes are done and the result is posted (later while the previous result beat waits),
// set by the three-step remainder unit and the single read-modify-write port of the bit table.
// Reset: arst_n is asynchronous, active low; afterwards the table is cleared one word per cycle
// until all TABLE_WORDS words are zero, during which s_axis_tready stays low.
module bloom_filter_test_and_set #(
	parameter int unsigned TABLE_WORDS = bft_pkg::TABLE_WORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] key_byte
	input  logic       s_axis_tlast,  // last_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // [0] seen, [7:1] zero
);
	import bft_pkg::*;

	// The controller sequences the table clear, byte absorption, the eight probes and the
	// result post; the datapath holds the hashes, the remainder unit, the table and the
	// result register. A result beat may wait at the output while the next key's bytes
	// are already being absorbed; only the posting of the next result waits for it.
	bft_cmd_t cmd;
	bft_sts_t sts;
	logic     seen;

	bft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bft_dpath #(
		.TABLE_WORDS (TABLE_WORDS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_byte  (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.seen      (seen)
	);

	assign m_axis_tdata = {7'd0, seen};

endmodule

// File: hw/rtl/bft_ctrl.sv
module bft_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  bft_pkg::bft_sts_t sts,
	output bft_pkg::bft_cmd_t cmd
);
	import bft_pkg::*;

	bft_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.absorb = 1'b1;
					if (in_last) begin
						cmd.seen_init = 1'b1;
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.mem_read = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (sts.last_probe) begin
					state_d = ST_DONE;
				end else begin
					cmd.next_probe = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					cmd.restart = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/bft_dpath.sv
module bft_dpath #(
	parameter int unsigned TABLE_WORDS = bft_pkg::TABLE_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        key_byte,
	input  bft_pkg::bft_cmd_t cmd,
	output bft_pkg::bft_sts_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              seen
);
	import bft_pkg::*;

	localparam int unsigned WAW = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
	localparam logic [WAW-1:0] LAST_WORD = WAW'(TABLE_WORDS - 1);
	localparam logic [27:0] DIVISOR = 28'(TABLE_WORDS);
	// floor(2^27 / TABLE_WORDS); the quotient estimate is then low by at most one.
	localparam logic [27:0] RECIP = 28'((64'd1 << 27) / 64'(TABLE_WORDS));
	localparam int unsigned CW = $clog2(DIV_STEPS);

	logic [31:0]        hash_q [NUM_HASH];
	logic [31:0]        hash_d [NUM_HASH];
	logic [31:0]        addend_q;
	logic               parity_q;
	logic [2:0]         idx_q;
	logic [WAW-1:0]     clr_addr_q;
	logic [26:0]        x_q;
	logic [27:0]        quo_q;
	logic [27:0]        qd_q;
	logic [WAW-1:0]     rem_q;
	logic [CW-1:0]      step_q;
	logic [4:0]         bitpos_q;
	logic [31:0]        rd_data_q;
	logic               all_set_q;
	logic               out_valid_q;
	logic               seen_q;
	logic [31:0]        mem [TABLE_WORDS];

	logic [31:0]        s;
	logic [31:0]        mysql_prod;
	logic [31:0]        crc;
	logic [31:0]        fin;
	logic [54:0]        recip_prod;
	logic [27:0]        qd_prod;
	logic [27:0]        rem_diff;
	logic [27:0]        rem_fix;
	logic [31:0]        mask;
	logic               bit_set;
	logic               mem_we;
	logic [WAW-1:0]     mem_wa;
	logic [31:0]        mem_wd;

	// Per-byte hash update.
	always_comb begin
		s = {{24{key_byte[7]}}, key_byte};
		hash_d[0] = hash_q[0] * 32'd33 + s;
		hash_d[1] = hash_q[1] * 32'd31 + s;
		if (!parity_q) begin
			hash_d[2] = hash_q[2] ^ ((hash_q[2] << 7) ^ s ^ (hash_q[2] >> 3));
		end else begin
			hash_d[2] = hash_q[2] ^ ~((hash_q[2] << 11) ^ s ^ (hash_q[2] >> 5));
		end
		hash_d[3] = (hash_q[3] * FNV_PRIME) ^ s;
		mysql_prod = ({26'd0, hash_q[4][5:0]} + addend_q) * s;
		hash_d[4] = hash_q[4] ^ (mysql_prod + (hash_q[4] << 8));
		crc = hash_q[5] ^ {24'd0, key_byte};
		for (int k = 0; k < 8; k++) begin
			crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
		end
		hash_d[5] = crc;
		hash_d[6] = hash_q[6] * 32'd131 + s;
		hash_d[7] = hash_q[7] * 32'd1313 + s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_HASH; k++) begin
				hash_q[k] <= hash_init(3'(k));
			end
			addend_q <= MYSQL_ADDEND_INIT;
			parity_q <= 1'b0;
		end else if (cmd.restart) begin
			for (int k = 0; k < NUM_HASH; k++) begin
				hash_q[k] <= hash_init(3'(k));
			end
			addend_q <= MYSQL_ADDEND_INIT;
			parity_q <= 1'b0;
		end else if (cmd.absorb) begin
			for (int k = 0; k < NUM_HASH; k++) begin
				hash_q[k] <= hash_d[k];
			end
			addend_q <= addend_q + MYSQL_ADDEND_INC;
			parity_q <= ~parity_q;
		end
	end

	// Remainder of the upper 27 hash bits by the table word count, by reciprocal
	// multiplication: estimate the quotient, multiply back, subtract, then correct once.
	// The three registers form a short pipeline that is valid after three steps.
	assign fin = hash_final(idx_q, hash_q[idx_q]);
	assign recip_prod = {28'd0, x_q} * {27'd0, RECIP};
	assign qd_prod = quo_q * DIVISOR;
	assign rem_diff = {1'b0, x_q} - qd_q;
	assign rem_fix = (rem_diff >= DIVISOR) ? (rem_diff - DIVISOR) : rem_diff;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			x_q      <= fin[31:5];
			bitpos_q <= fin[4:0];
			step_q   <= '0;
		end else if (cmd.div_step) begin
			quo_q  <= recip_prod[54:27];
			qd_q   <= qd_prod;
			rem_q  <= rem_fix[WAW-1:0];
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			clr_addr_q <= '0;
			all_set_q  <= 1'b1;
		end else begin
			if (cmd.restart) begin
				idx_q <= '0;
			end else if (cmd.next_probe) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.clr_we) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.seen_init) begin
				all_set_q <= 1'b1;
			end else if (cmd.check) begin
				all_set_q <= all_set_q & bit_set;
			end
		end
	end

	// Bit b of the table is bit (31 - b mod 32) of its word.
	assign mask = 32'h80000000 >> bitpos_q;
	assign bit_set = (rd_data_q & mask) != 32'd0;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = rem_q;
		mem_wd = rd_data_q | mask;
		if (cmd.clr_we) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else if (cmd.check && !bit_set) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.mem_read) begin
			rd_data_q <= mem[rem_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			seen_q <= all_set_q;
		end
	end

	assign out_valid = out_valid_q;
	assign seen = seen_q;

	assign sts.clr_done   = (clr_addr_q == LAST_WORD);
	assign sts.div_last   = (step_q == CW'(DIV_STEPS - 1));
	assign sts.last_probe = (idx_q == 3'(NUM_HASH - 1));
	assign sts.out_busy   = out_valid_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

// Keeps its own copy of the eight running hashes and of the bit table, and
// works out the seen flag that each key end must produce.
class bloom_scoreboard;
	int unsigned n_words;
	logic [31:0] run_hash [8];
	logic [31:0] mysql_add;
	logic        odd_byte;
	logic [31:0] bit_table [];
	logic        seen_queue [$];
	int          n_errors;

	function new(int unsigned words);
		n_words = words;
		bit_table = new[words];
		foreach (bit_table[i]) bit_table[i] = '0;
		n_errors = 0;
		restart();
	endfunction

	function void restart();
		foreach (run_hash[k]) run_hash[k] = bft_pkg::hash_init(3'(k));
		mysql_add = bft_pkg::MYSQL_ADDEND_INIT;
		odd_byte = 1'b0;
	endfunction

	// Called for every accepted input beat.
	function void note_beat(logic [7:0] u, logic last);
		logic [31:0] s;
		logic [31:0] h;
		logic [31:0] fh;
		logic [63:0] bit_idx;
		int unsigned word;
		logic [31:0] mask;
		int hits;
		s = {{24{u[7]}}, u};
		run_hash[0] = run_hash[0] * 32'd33 + s;
		run_hash[1] = run_hash[1] * 32'd31 + s;
		h = run_hash[2];
		if (!odd_byte) begin
			h = h ^ ((h << 7) ^ s ^ (h >> 3));
		end else begin
			h = h ^ ~((h << 11) ^ s ^ (h >> 5));
		end
		run_hash[2] = h;
		run_hash[3] = (run_hash[3] * bft_pkg::FNV_PRIME) ^ s;
		h = run_hash[4];
		h = h ^ (((h & 32'd63) + mysql_add) * s + (h << 8));
		run_hash[4] = h;
		mysql_add = mysql_add + bft_pkg::MYSQL_ADDEND_INC;
		// Reflected CRC-32 works on the unsigned byte.
		h = run_hash[5] ^ {24'd0, u};
		for (int i = 0; i < 8; i++) begin
			h = h[0] ? ((h >> 1) ^ bft_pkg::CRC_POLY) : (h >> 1);
		end
		run_hash[5] = h;
		run_hash[6] = run_hash[6] * 32'd131 + s;
		run_hash[7] = run_hash[7] * 32'd1313 + s;
		odd_byte = ~odd_byte;
		if (!last) return;
		// Probes run in order, so a bit set by an earlier probe of this key
		// already counts as set for a later one.
		hits = 0;
		for (int k = 0; k < 8; k++) begin
			fh = run_hash[k];
			if (k == 2) fh = fh & 32'h7FFF_FFFF;
			if (k == 5) fh = ~fh;
			bit_idx = {32'd0, fh} % (64'(n_words) * 64'd32);
			word = int'(bit_idx / 64'd32);
			mask = 32'h8000_0000 >> bit_idx[4:0];
			if ((bit_table[word] & mask) != 0) begin
				hits++;
			end else begin
				bit_table[word] = bit_table[word] | mask;
			end
		end
		seen_queue.push_back(hits == 8);
		restart();
	endfunction

	// Called for every accepted output beat.
	function void check_result(logic [7:0] data);
		logic exp_seen;
		if (seen_queue.size() == 0) begin
			$error("result beat 0x%02h arrived with nothing expected", data);
			n_errors++;
			return;
		end
		exp_seen = seen_queue.pop_front();
		if (data[0] !== exp_seen) begin
			$error("seen: expected %0b, actual %0b", exp_seen, data[0]);
			n_errors++;
		end
		if (data[7:1] !== 7'd0) begin
			$error("padding: expected 0, actual 0x%02h", data[7:1]);
			n_errors++;
		end
	endfunction
endclass

module tb_top;
	// A small table keeps the clearing pass short and lets keys collide
	// often enough that seen is reported as both values.
	localparam int unsigned N_WORDS = 64;
	localparam int unsigned TARGET_BEATS = 1000;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned HOLD_CYCLES = 3000;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;  // [7:0] key_byte
	logic       s_axis_tlast;  // last_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;  // [0] seen, [7:1] zero

	bloom_filter_test_and_set #(
		.TABLE_WORDS(N_WORDS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	bloom_scoreboard filter_model;

	// Keys up to eight bytes are remembered so that they can be sent again;
	// a repeated key is the reliable way to see the seen flag go high.
	typedef struct {
		logic [63:0] bytes;
		int          len;
	} short_key_t;

	short_key_t  key_history [$];
	logic [7:0]  key_buf [64];
	int unsigned beats_sent;
	int unsigned cycle_count;
	int unsigned results_seen;
	logic        no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit: a generous ceiling on the whole run.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one beat and waits for its handshake; the valid stays high
	// afterwards, so back-to-back beats never drop it within one step.
	task automatic send_beat(input logic [7:0] kb, input logic last);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= kb;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		filter_model.note_beat(kb, last);
		beats_sent++;
	endtask

	task automatic send_key(input int len);
		short_key_t entry;
		for (int i = 0; i < len; i++) begin
			send_beat(key_buf[i], i == len - 1);
		end
		if (len <= 8) begin
			entry.len = len;
			entry.bytes = '0;
			for (int i = 0; i < len; i++) entry.bytes[i*8 +: 8] = key_buf[i];
			key_history.push_back(entry);
		end
	endtask

	task automatic send_random_key(input int len);
		for (int i = 0; i < len; i++) key_buf[i] = 8'($urandom_range(1, 255));
		send_key(len);
	endtask

	task automatic resend_old_key();
		short_key_t entry;
		entry = key_history[$urandom_range(0, key_history.size() - 1)];
		for (int i = 0; i < entry.len; i++) key_buf[i] = entry.bytes[i*8 +: 8];
		send_key(entry.len);
	endtask

	// Receiver: checks each accepted result beat, then decides its ready for
	// the next edge. Once, after a few results, it holds off for a long
	// stretch so that the block backs up and stalls its input.
	initial begin
		int unsigned gap;
		logic        held;
		m_axis_tready = 1'b0;
		held = 1'b0;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				filter_model.check_result(m_axis_tdata);
				results_seen++;
			end
			if (!held && results_seen == 6) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned r;
		filter_model = new(N_WORDS);
		beats_sent = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: single-byte keys at the extremes and at the sign
		// boundary, the same key twice so that all its bits are already set,
		// and a longer key whose bytes alternate so that both branches of the
		// alternating-shift hash see both bit patterns.
		key_buf[0] = 8'h01; send_key(1);
		key_buf[0] = 8'hFF; send_key(1);
		key_buf[0] = 8'h80; send_key(1);
		key_buf[0] = 8'h7F; send_key(1);
		key_buf[0] = 8'h01; send_key(1);
		key_buf[0] = 8'h55; key_buf[1] = 8'hAA; key_buf[2] = 8'hFF;
		key_buf[3] = 8'h01; key_buf[4] = 8'h80; key_buf[5] = 8'h7F;
		send_key(6);
		key_buf[0] = 8'h55; key_buf[1] = 8'hAA; key_buf[2] = 8'hFF;
		key_buf[3] = 8'h01; key_buf[4] = 8'h80; key_buf[5] = 8'h7F;
		send_key(6);
		key_buf[0] = 8'hFF; key_buf[1] = 8'hFF; send_key(2);

		// Random part: mostly fresh short keys, a share of repeats, and a few
		// long keys. Phases without any idling alternate with idling ones.
		while (beats_sent < TARGET_BEATS) begin
			no_gaps = ((beats_sent / 150) % 3) == 1;
			r = $urandom_range(0, 99);
			if (r < 30) begin
				resend_old_key();
			end else if (r < 90) begin
				send_random_key($urandom_range(1, 8));
			end else begin
				send_random_key($urandom_range(9, 40));
			end
		end
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;

		while (filter_model.seen_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (filter_model.n_errors == 0 && filter_model.seen_queue.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// File: filelist.f
hw/rtl/bft_pkg.sv
hw/rtl/bft_ctrl.sv
hw/rtl/bft_dpath.sv
hw/rtl/bloom_filter_test_and_set.sv
tb/tb_top.sv
